// ----- hw/rtl/stcp_pkg.sv -----
// ----------------------------------------------------------------------------
// stcp_pkg
// Shared types, command codes and key table for the serial tuning command
// parser.
// ----------------------------------------------------------------------------
package stcp_pkg;

    localparam int MAX_LINE_DEF      = 256;
    localparam int MANTISSA_BITS_DEF = 32;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_POINT = 8'h2e;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int NUM_KEYS = 11;

    localparam logic [3:0] CMD_UP = 4'd0;
    localparam logic [3:0] CMD_UD = 4'd1;
    localparam logic [3:0] CMD_VP = 4'd2;
    localparam logic [3:0] CMD_VI = 4'd3;
    localparam logic [3:0] CMD_S1 = 4'd4;
    localparam logic [3:0] CMD_S2 = 4'd5;
    localparam logic [3:0] CMD_S3 = 4'd6;
    localparam logic [3:0] CMD_S4 = 4'd7;
    localparam logic [3:0] CMD_S5 = 4'd8;
    localparam logic [3:0] CMD_S6 = 4'd9;
    localparam logic [3:0] CMD_ST = 4'd10;

    localparam logic [1:0] REG_TURN_MAG   = 2'd0;
    localparam logic [1:0] REG_STEER_STEP = 2'd1;
    localparam logic [1:0] REG_STEER_LIM  = 2'd2;

    localparam logic [14:0] TURN_MAG_RST   = 15'd2000;
    localparam logic [6:0]  STEER_STEP_RST = 7'd10;
    localparam logic [6:0]  STEER_LIM_RST  = 7'd100;
    localparam logic [6:0]  SPEED_MAG_RST  = 7'd20;

    // first received byte sits in the low byte
    localparam logic [23:0] KEY_TABLE [NUM_KEYS] = '{
        24'h3a5055, 24'h3a4455, 24'h3a5056, 24'h3a4956,
        24'h3a3173, 24'h3a3273, 24'h3a3373, 24'h3a3473,
        24'h3a3573, 24'h3a3673, 24'h3a7473
    };

    typedef struct packed {
        logic       found;
        logic [3:0] command;
    } t_key_hit;

    typedef struct packed {
        logic        format_ok;
        logic [3:0]  command;
        logic        value_ok;
        logic [31:0] mantissa;
        logic [7:0]  frac_digits;
    } t_cmd_rec;

    typedef struct packed {
        logic        format_ok;
        logic [3:0]  command;
        logic        value_ok;
        logic [31:0] mantissa;
        logic [7:0]  frac_digits;
        logic [7:0]  steer_out;
        logic [15:0] turn_out;
        logic [6:0]  steer_magnitude;
    } t_result;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [14:0] data;
    } t_cfg_wr;

    function automatic t_key_hit stcp_key_match(input logic [23:0] key);
        t_key_hit hit;
        hit = '0;
        for (int k = NUM_KEYS - 1; k >= 0; k--) begin
            if (key == KEY_TABLE[k]) begin
                hit.found   = 1'b1;
                hit.command = 4'(k);
            end
        end
        return hit;
    endfunction

endpackage

// ----- hw/rtl/stcp_fifo.sv -----
// ----------------------------------------------------------------------------
// stcp_fifo
// Small register queue, used between front and back and on the result side.
// ----------------------------------------------------------------------------
module stcp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_head_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> $stable(o_data))
        else $error("queue head changed without a pop");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

endmodule

// ----- hw/rtl/stcp_front.sv -----
// ----------------------------------------------------------------------------
// stcp_front
// Line framing, key capture and on-the-fly decimal accumulation; emits one
// command record per CR LF terminated line.
// ----------------------------------------------------------------------------
module stcp_front import stcp_pkg::*; #(
    parameter int MAX_LINE      = MAX_LINE_DEF,
    parameter int MANTISSA_BITS = MANTISSA_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_rec_valid,
    output t_cmd_rec   o_rec
);
    localparam int LC_W = $clog2(MAX_LINE);
    localparam int MB   = MANTISSA_BITS;

    logic [LC_W-1:0] r_line_count;
    logic            r_cr_seen;
    logic [23:0]     r_key;
    logic            r_pay_ok;
    logic            r_point;
    logic [MB-1:0]   r_acc;
    logic [7:0]      r_frac;

    logic            is_digit;
    logic            in_key;
    logic [MB+3:0]   acc_wide;
    logic [MB-1:0]   n_acc;
    logic [23:0]     n_key;
    logic [MB+31:0]  acc_ext;
    t_key_hit        hit;
    logic            vok;

    assign is_digit = (i_rx_byte >= CHAR_ZERO) && (i_rx_byte <= CHAR_NINE);
    assign in_key   = (r_line_count < LC_W'(3));
    // acc * 10 + digit, saturating at the mantissa width
    assign acc_wide = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                    + {{MB{1'b0}}, i_rx_byte[3:0]};
    assign n_acc    = (|acc_wide[MB+3:MB]) ? '1 : acc_wide[MB-1:0];
    assign n_key    = r_key | ({16'b0, i_rx_byte} << (5'd8 * 5'(r_line_count[1:0])));
    assign acc_ext  = {32'b0, r_acc};

    assign hit = stcp_key_match(r_key);
    assign vok = hit.found && r_pay_ok;

    assign o_rec_valid       = i_byte_valid && r_cr_seen && (i_rx_byte == CHAR_LF);
    assign o_rec.format_ok   = hit.found;
    assign o_rec.command     = hit.found ? hit.command : CMD_UP;
    assign o_rec.value_ok    = vok;
    assign o_rec.mantissa    = vok ? acc_ext[31:0] : 32'd0;
    assign o_rec.frac_digits = vok ? r_frac : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count <= '0;
            r_cr_seen    <= 1'b0;
            r_key        <= '0;
            r_pay_ok     <= 1'b1;
            r_point      <= 1'b0;
            r_acc        <= '0;
            r_frac       <= '0;
        end else if (i_byte_valid) begin
            if (r_cr_seen || (!r_cr_seen && i_rx_byte != CHAR_CR &&
                              r_line_count == LC_W'(MAX_LINE - 1))) begin
                // end of line, broken CR LF, or line too long
                r_line_count <= '0;
                r_cr_seen    <= 1'b0;
                r_key        <= '0;
                r_pay_ok     <= 1'b1;
                r_point      <= 1'b0;
                r_acc        <= '0;
                r_frac       <= '0;
            end else if (i_rx_byte == CHAR_CR) begin
                r_cr_seen <= 1'b1;
            end else begin
                r_line_count <= r_line_count + 1'b1;
                if (in_key) begin
                    r_key <= n_key;
                end else if (is_digit) begin
                    r_acc <= n_acc;
                    if (r_point && r_frac != 8'hff) begin
                        r_frac <= r_frac + 1'b1;
                    end
                end else if (i_rx_byte == CHAR_POINT) begin
                    r_point <= 1'b1;
                    if (r_point) begin
                        r_pay_ok <= 1'b0;
                    end
                end else begin
                    r_pay_ok <= 1'b0;
                end
            end
        end
    end

    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_byte_valid && r_cr_seen) |=> (r_line_count == '0 && !r_cr_seen))
        else $error("line not restarted after CR");

    a_cr_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_byte_valid && !r_cr_seen && i_rx_byte == CHAR_CR) |=> r_cr_seen)
        else $error("CR beat not marked");

    a_frac_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frac != 8'd0) |-> r_point)
        else $error("fraction digits counted without a point");

endmodule

// ----- hw/rtl/stcp_back.sv -----
// ----------------------------------------------------------------------------
// stcp_back
// Executes command records: updates the held steer and turn drives and the
// speed magnitude, and builds the result beat.
// ----------------------------------------------------------------------------
module stcp_back import stcp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg_wr  i_cfg,
    input  logic     i_exec,
    input  t_cmd_rec i_rec,
    output t_result  o_result
);
    logic [14:0] r_turn_mag;
    logic [6:0]  r_step;
    logic [6:0]  r_limit;
    logic [6:0]  r_mag;
    logic [7:0]  r_steer;
    logic [15:0] r_turn;

    logic [6:0]  n_mag;
    logic [7:0]  n_steer;
    logic [15:0] n_turn;
    logic [7:0]  mag_sum;

    assign mag_sum = {1'b0, r_mag} + {1'b0, r_step};

    always_comb begin
        n_mag   = r_mag;
        n_steer = r_steer;
        n_turn  = r_turn;
        if (i_rec.format_ok) begin
            unique case (i_rec.command)
                CMD_S1: n_steer = 8'd0 - {1'b0, r_mag};
                CMD_S2: n_steer = {1'b0, r_mag};
                CMD_S3: n_turn  = 16'd0 - {1'b0, r_turn_mag};
                CMD_S4: n_turn  = {1'b0, r_turn_mag};
                CMD_S5: n_mag   = (mag_sum > {1'b0, r_limit}) ? r_limit : mag_sum[6:0];
                CMD_S6: n_mag   = (r_mag > r_step) ? r_mag - r_step : 7'd0;
                CMD_ST: begin
                    n_steer = 8'd0;
                    n_turn  = 16'd0;
                end
                default: ;
            endcase
        end
    end

    assign o_result.format_ok       = i_rec.format_ok;
    assign o_result.command         = i_rec.command;
    assign o_result.value_ok        = i_rec.value_ok;
    assign o_result.mantissa        = i_rec.mantissa;
    assign o_result.frac_digits     = i_rec.frac_digits;
    assign o_result.steer_out       = n_steer;
    assign o_result.turn_out        = n_turn;
    assign o_result.steer_magnitude = n_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_mag <= TURN_MAG_RST;
            r_step     <= STEER_STEP_RST;
            r_limit    <= STEER_LIM_RST;
            r_mag      <= SPEED_MAG_RST;
            r_steer    <= '0;
            r_turn     <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_TURN_MAG:   r_turn_mag <= i_cfg.data;
                    REG_STEER_STEP: r_step     <= i_cfg.data[6:0];
                    REG_STEER_LIM:  r_limit    <= i_cfg.data[6:0];
                    default: ;
                endcase
            end
            if (i_exec) begin
                r_mag   <= n_mag;
                r_steer <= n_steer;
                r_turn  <= n_turn;
            end
        end
    end

    a_s5_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_exec && i_rec.format_ok && i_rec.command == CMD_S5)
            |=> (r_mag <= $past(r_limit)))
        else $error("speed magnitude above limit after step up");

    a_unknown_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_exec && !i_rec.format_ok)
            |=> ($stable(r_mag) && $stable(r_steer) && $stable(r_turn)))
        else $error("unknown key changed a drive");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_exec |=> ($stable(r_mag) && $stable(r_steer) && $stable(r_turn)))
        else $error("drive changed without a command");

endmodule

// ----- hw/rtl/serial_tuning_command_parser.sv -----
// ----------------------------------------------------------------------------
// serial_tuning_command_parser
// Frames CR LF terminated command lines from received bytes, decodes the key
// and decimal payload, and reports the drive state each command leaves.
//
//   channel   direction  handshake              payload
//   bytes     in         push / full            i_rx_byte
//   results   out        empty / pop            o_format_ok .. o_steer_magnitude
//   config    in         i_cfg_valid / ready    i_cfg_index, i_cfg_data
//
// One byte is taken every cycle while full is low; full rises only while the
// command queue between the framer and the executor holds QUEUE_DEPTH records.
// A result reaches the ports by way of the command queue and then the result
// queue, in which it waits until it is popped.
// The executor retires one record per cycle while the result queue has room.
// Synchronous active-low reset; no clearing pass, the block is ready at once.
// ----------------------------------------------------------------------------
module serial_tuning_command_parser import stcp_pkg::*; #(
    parameter int MAX_LINE      = MAX_LINE_DEF,
    parameter int MANTISSA_BITS = MANTISSA_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic [7:0]         i_rx_byte,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output logic               o_format_ok,
    output logic [3:0]         o_command,
    output logic               o_value_ok,
    output logic [31:0]        o_mantissa,
    output logic [7:0]         o_frac_digits,
    output logic signed [7:0]  o_steer_out,
    output logic signed [15:0] o_turn_out,
    output logic [6:0]         o_steer_magnitude,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data
);
    localparam int REC_W = $bits(t_cmd_rec);
    localparam int RES_W = $bits(t_result);

    logic             byte_take;
    logic             rec_valid;
    t_cmd_rec         front_rec;
    t_cmd_rec         head_rec;
    logic [REC_W-1:0] head_vec;
    logic             cmd_empty;
    logic             res_full;
    logic             exec;
    t_result          back_res;
    t_result          out_res;
    logic [RES_W-1:0] out_vec;
    t_cfg_wr          cfg;

    assign byte_take   = push && !full;
    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    stcp_front #(
        .MAX_LINE      (MAX_LINE),
        .MANTISSA_BITS (MANTISSA_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (byte_take),
        .i_rx_byte    (i_rx_byte),
        .o_rec_valid  (rec_valid),
        .o_rec        (front_rec)
    );

    stcp_fifo #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_valid),
        .i_data  (front_rec),
        .o_full  (full),
        .i_pop   (exec),
        .o_empty (cmd_empty),
        .o_data  (head_vec)
    );

    assign head_rec = t_cmd_rec'(head_vec);
    assign exec     = !cmd_empty && !res_full;

    stcp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_exec   (exec),
        .i_rec    (head_rec),
        .o_result (back_res)
    );

    stcp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (exec),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_vec)
    );

    assign out_res           = t_result'(out_vec);
    assign o_format_ok       = out_res.format_ok;
    assign o_command         = out_res.command;
    assign o_value_ok        = out_res.value_ok;
    assign o_mantissa        = out_res.mantissa;
    assign o_frac_digits     = out_res.frac_digits;
    assign o_steer_out       = out_res.steer_out;
    assign o_turn_out        = out_res.turn_out;
    assign o_steer_magnitude = out_res.steer_magnitude;

endmodule

// ----- tb/serial_tuning_command_parser_tb.sv -----
// ----------------------------------------------------------------------------
// serial_tuning_command_parser_tb
// Sends received bytes into the parser and checks every command line result
// field by field against a predictor of the line framer, the key and number
// decoder and the held drive state. A table of hand-written lines comes
// first, then random lines under several register settings and idle mixes.
// ----------------------------------------------------------------------------
module serial_tuning_command_parser_tb;
    import stcp_pkg::*;

    localparam int          DIR_ROWS        = 21;
    localparam int          BYTES_PER_PHASE = 100;
    localparam int          NUM_PHASES      = 7;
    localparam int          DRAIN_LIMIT     = 5000;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam longint unsigned MANT_MAX =
        64'hFFFF_FFFF_FFFF_FFFF >> (64 - MANTISSA_BITS_DEF);

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               push        = 1'b0;
    logic [7:0]         i_rx_byte   = '0;
    logic               full;
    logic               empty;
    logic               pop         = 1'b0;
    logic               o_format_ok;
    logic [3:0]         o_command;
    logic               o_value_ok;
    logic [31:0]        o_mantissa;
    logic [7:0]         o_frac_digits;
    logic signed [7:0]  o_steer_out;
    logic signed [15:0] o_turn_out;
    logic [6:0]         o_steer_magnitude;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [14:0]        i_cfg_data  = '0;

    serial_tuning_command_parser u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .i_rx_byte         (i_rx_byte),
        .full              (full),
        .empty             (empty),
        .pop               (pop),
        .o_format_ok       (o_format_ok),
        .o_command         (o_command),
        .o_value_ok        (o_value_ok),
        .o_mantissa        (o_mantissa),
        .o_frac_digits     (o_frac_digits),
        .o_steer_out       (o_steer_out),
        .o_turn_out        (o_turn_out),
        .o_steer_magnitude (o_steer_magnitude),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // register copies and parser state as the block should hold them
    logic [14:0]        turn_mag    = TURN_MAG_RST;
    logic [6:0]         steer_step  = STEER_STEP_RST;
    logic [6:0]         steer_limit = STEER_LIM_RST;
    int unsigned        line_len    = 0;
    bit                 cr_pending  = 1'b0;
    logic [23:0]        key_acc     = '0;
    bit                 digits_ok   = 1'b1;
    int unsigned        points      = 0;
    longint unsigned    mant_acc    = 0;
    int unsigned        frac_cnt    = 0;
    logic [6:0]         speed       = SPEED_MAG_RST;
    logic signed [7:0]  steer       = '0;
    logic signed [15:0] turn        = '0;

    t_result     cmd_results_q [$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatches    = 0;
    int          bytes_sent    = 0;
    int          results_seen  = 0;
    int          known_keys    = 0;
    int unsigned cycle_count   = 0;

    // directed lines: text, optional filler run, byte that follows CR
    string       dir_text  [DIR_ROWS] = '{
        "s2:", "s1:", "s4:", "s3:", "st:", "UP:12.5", "UD:4294967295",
        "VP:99999999999.99", "VI:.", "UP:1..2", "XX:5", "s", "", "s5:",
        "s6:-3", "UP:5", "VP:7", "UP:", "UD:", "UP:1", "s2:"
    };
    int          dir_pad_n [DIR_ROWS] = '{
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 252, 253, 1, 0
    };
    logic [7:0]  dir_pad_b [DIR_ROWS] = '{
        8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39,
        8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h31, 8'h00,
        8'h39
    };
    logic [7:0]  dir_tail  [DIR_ROWS] = '{
        CHAR_LF, CHAR_LF, CHAR_LF, CHAR_LF, CHAR_LF, CHAR_LF, CHAR_LF,
        CHAR_LF, CHAR_LF, CHAR_LF, CHAR_LF, CHAR_LF, CHAR_LF, CHAR_LF,
        CHAR_LF, 8'h78, CHAR_CR, CHAR_LF, CHAR_LF, CHAR_LF, CHAR_LF
    };
    bit          dir_typed [DIR_ROWS] = '{
        1, 1, 1, 1, 1, 0, 1, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };
    t_result     dir_want  [DIR_ROWS] = '{
        '{1'b1, CMD_S2, 1'b1, 32'd0, 8'd0, 8'd20, 16'd0, 7'd20},
        '{1'b1, CMD_S1, 1'b1, 32'd0, 8'd0, -8'sd20, 16'd0, 7'd20},
        '{1'b1, CMD_S4, 1'b1, 32'd0, 8'd0, -8'sd20, 16'd2000, 7'd20},
        '{1'b1, CMD_S3, 1'b1, 32'd0, 8'd0, -8'sd20, -16'sd2000, 7'd20},
        '{1'b1, CMD_ST, 1'b1, 32'd0, 8'd0, 8'd0, 16'd0, 7'd20},
        '0,
        '{1'b1, CMD_UD, 1'b1, 32'hFFFF_FFFF, 8'd0, 8'd0, 16'd0, 7'd20},
        '0,
        '0,
        '{1'b1, CMD_UP, 1'b0, 32'd0, 8'd0, 8'd0, 16'd0, 7'd20},
        '{1'b0, 4'd0, 1'b0, 32'd0, 8'd0, 8'd0, 16'd0, 7'd20},
        '0, '0, '0, '0, '0, '0, '0, '0, '0, '0
    };

    function automatic void restart_line();
        line_len   = 0;
        cr_pending = 1'b0;
        key_acc    = '0;
        digits_ok  = 1'b1;
        points     = 0;
        mant_acc   = 0;
        frac_cnt   = 0;
    endfunction

    // advances the parser by one byte; returns 1 when a command line completes
    function automatic bit parse_byte(input logic [7:0] b, output t_result res);
        bit              hit;
        int unsigned     cmd;
        longint unsigned d;
        int              sum;
        res = '0;
        if (!cr_pending) begin
            if (b == CHAR_CR) begin
                cr_pending = 1'b1;
            end else begin
                if (line_len < 3) begin
                    key_acc[8*line_len +: 8] = b;
                end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                    d = longint'(b - CHAR_ZERO);
                    if (mant_acc > (MANT_MAX - d) / 10)
                        mant_acc = MANT_MAX;
                    else
                        mant_acc = mant_acc * 10 + d;
                    if (points != 0 && frac_cnt < 255)
                        frac_cnt++;
                end else if (b == CHAR_POINT) begin
                    if (points < 3)
                        points++;
                    if (points >= 2)
                        digits_ok = 1'b0;
                end else begin
                    digits_ok = 1'b0;
                end
                line_len++;
                if (line_len >= MAX_LINE_DEF)
                    restart_line();
            end
            return 1'b0;
        end
        // anything but LF after CR drops the line and the byte
        if (b != CHAR_LF) begin
            restart_line();
            return 1'b0;
        end
        hit = 1'b0;
        cmd = 0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (!hit && key_acc == KEY_TABLE[k]) begin
                hit = 1'b1;
                cmd = k;
            end
        end
        if (hit) begin
            res.format_ok = 1'b1;
            res.command   = 4'(cmd);
            res.value_ok  = digits_ok;
            if (digits_ok) begin
                res.mantissa    = mant_acc[31:0];
                res.frac_digits = 8'(frac_cnt);
            end
            case (res.command)
                CMD_S1: steer = -$signed({1'b0, speed});
                CMD_S2: steer = $signed({1'b0, speed});
                CMD_S3: turn = -$signed({1'b0, turn_mag});
                CMD_S4: turn = $signed({1'b0, turn_mag});
                CMD_S5: begin
                    sum = speed + steer_step;
                    if (sum > steer_limit)
                        sum = steer_limit;
                    speed = 7'(sum);
                end
                CMD_S6: speed = (speed > steer_step) ? speed - steer_step : 7'd0;
                CMD_ST: begin
                    steer = '0;
                    turn  = '0;
                end
                default: ;
            endcase
        end
        res.steer_out       = steer;
        res.turn_out        = turn;
        res.steer_magnitude = speed;
        restart_line();
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        t_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        bytes_sent++;
        if (parse_byte(b, res))
            cmd_results_q.push_back(res);
    endtask

    // hold the byte stream until every expected result has been taken
    task automatic drain();
        int n;
        push <= 1'b0;
        for (n = 0; cmd_results_q.size() != 0 && n < DRAIN_LIMIT; n++)
            @(posedge i_clk);
        if (cmd_results_q.size() != 0) begin
            $error("%0d results still outstanding", cmd_results_q.size());
            mismatches++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [14:0] turn_v, input logic [6:0] step_v,
                                  input logic [6:0] lim_v);
        logic [1:0]  idx  [3];
        logic [14:0] data [3];
        idx  = '{REG_TURN_MAG, REG_STEER_STEP, REG_STEER_LIM};
        // upper data bits of the narrow registers are don't care
        data = '{turn_v, {8'($urandom), step_v}, {8'($urandom), lim_v}};
        drain();
        i_cfg_valid <= 1'b1;
        for (int i = 0; i < 3; i++) begin
            i_cfg_index <= idx[i];
            i_cfg_data  <= data[i];
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            case (idx[i])
                REG_TURN_MAG:   turn_mag    = data[i];
                REG_STEER_STEP: steer_step  = data[i][6:0];
                REG_STEER_LIM:  steer_limit = data[i][6:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_line();
        logic [7:0]  line_q [$];
        logic [23:0] key;
        int          sel;
        int          n;
        int          pt;
        int          pos;
        sel = $urandom_range(99);
        if (sel < 8) begin
            n = $urandom_range(1, 6);
            repeat (n) line_q.push_back(8'($urandom));
        end else begin
            key = KEY_TABLE[$urandom_range(NUM_KEYS - 1)];
            sel = $urandom_range(99);
            if (sel < 10) begin
                pos = $urandom_range(2);
                key[8*pos +: 8] = 8'($urandom);
            end
            if (sel >= 10 && sel < 15) begin
                // short line: part of a key and nothing more
                n = $urandom_range(0, 2);
                for (int i = 0; i < n; i++)
                    line_q.push_back(key[8*i +: 8]);
            end else begin
                for (int i = 0; i < 3; i++)
                    line_q.push_back(key[8*i +: 8]);
                sel = $urandom_range(99);
                n = (sel < 3)  ? $urandom_range(240, 262) :
                    (sel < 15) ? $urandom_range(9, 14) : $urandom_range(0, 6);
                pt = ($urandom_range(99) < 40) ? $urandom_range(0, n) : -1;
                for (int i = 0; i <= n; i++) begin
                    if (i == pt)
                        line_q.push_back(CHAR_POINT);
                    if (i < n)
                        line_q.push_back(CHAR_ZERO + 8'($urandom_range(9)));
                end
                // a stray point or a byte that is no part of a number
                if (line_q.size() > 3 && $urandom_range(99) < 6)
                    line_q[$urandom_range(3, line_q.size() - 1)] = CHAR_POINT;
                if (line_q.size() > 3 && $urandom_range(99) < 6)
                    line_q[$urandom_range(3, line_q.size() - 1)] = 8'($urandom);
            end
        end
        sel = $urandom_range(99);
        if (sel < 88) begin
            line_q.push_back(CHAR_CR);
            line_q.push_back(CHAR_LF);
        end else if (sel < 94) begin
            line_q.push_back(CHAR_CR);
            line_q.push_back(8'($urandom));
        end
        foreach (line_q[i])
            send_byte(line_q[i]);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_sink
        t_result got;
        t_result want;
        if (pop && !empty) begin
            got = {o_format_ok, o_command, o_value_ok, o_mantissa, o_frac_digits,
                   o_steer_out, o_turn_out, o_steer_magnitude};
            results_seen++;
            if (got.format_ok === 1'b1)
                known_keys++;
            if (cmd_results_q.size() == 0) begin
                $error("result beat with nothing expected");
                mismatches++;
            end else begin
                want = cmd_results_q.pop_front();
                check_field("format_ok", want.format_ok, got.format_ok);
                check_field("command", want.command, got.command);
                check_field("value_ok", want.value_ok, got.value_ok);
                check_field("mantissa", want.mantissa, got.mantissa);
                check_field("frac_digits", want.frac_digits, got.frac_digits);
                check_field("steer_out", want.steer_out, got.steer_out);
                check_field("turn_out", want.turn_out, got.turn_out);
                check_field("steer_magnitude", want.steer_magnitude, got.steer_magnitude);
            end
        end
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("serial_tuning_command_parser: mismatch");
            $finish;
        end
    end

    initial begin
        int phase_start;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase % 3)
                0: begin
                    send_idle_pct = 19;
                    recv_idle_pct = 59;
                end
                1: begin
                    send_idle_pct = 59;
                    recv_idle_pct = 19;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 0) begin
                for (int r = 0; r < DIR_ROWS; r++) begin
                    for (int i = 0; i < dir_text[r].len(); i++)
                        send_byte(dir_text[r][i]);
                    repeat (dir_pad_n[r]) send_byte(dir_pad_b[r]);
                    send_byte(CHAR_CR);
                    send_byte(dir_tail[r]);
                    // LF was the last beat, so its result is the newest one queued
                    if (dir_typed[r])
                        cmd_results_q[cmd_results_q.size() - 1] = dir_want[r];
                end
            end else begin
                case (phase)
                    1: write_settings(15'd32767, 7'd127, 7'd127);
                    2: write_settings(15'd0, 7'd0, 7'd0);
                    3: write_settings(15'd1, 7'd1, 7'd127);
                    // limit drops below a magnitude that may have climbed high
                    5: write_settings(15'd12345, 7'd3, 7'd50);
                    default: write_settings(15'($urandom_range(32767)),
                                            7'($urandom_range(1, 40)),
                                            7'($urandom_range(127)));
                endcase
                phase_start = bytes_sent;
                while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
                    if ($urandom_range(99) < 3)
                        drain();
                    send_random_line();
                end
            end
        end
        drain();
        repeat (16) @(posedge i_clk);
        $display("covered %0d bytes and %0d command results (%0d with a known key)",
                 bytes_sent, results_seen, known_keys);
        $display("over %0d register settings, with and without idling on either side",
                 NUM_PHASES);
        if (mismatches == 0)
            $display("serial_tuning_command_parser: match");
        else
            $display("serial_tuning_command_parser: mismatch");
        $finish;
    end

endmodule
